[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBE_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, disabled during reset
`define SBE_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

[rtl/core/sbe_pkg.sv]
// shared opcodes, fault codes, field widths and the decoded item type
`default_nettype none

package sbe_pkg;

  localparam int FUNC_W  = 4;
  localparam int WORD_W  = 32;
  localparam int IP_W    = 16;
  localparam int FAULT_W = 3;
  localparam int FP_W    = 8;

  localparam logic [FUNC_W-1:0] OP_ADD    = 4'd0;
  localparam logic [FUNC_W-1:0] OP_SUB    = 4'd1;
  localparam logic [FUNC_W-1:0] OP_CONST  = 4'd2;
  localparam logic [FUNC_W-1:0] OP_BRT    = 4'd3;
  localparam logic [FUNC_W-1:0] OP_LOADG  = 4'd4;
  localparam logic [FUNC_W-1:0] OP_STOREG = 4'd5;
  localparam logic [FUNC_W-1:0] OP_EMIT   = 4'd6;
  localparam logic [FUNC_W-1:0] OP_CALL   = 4'd7;
  localparam logic [FUNC_W-1:0] OP_RET    = 4'd8;
  localparam logic [FUNC_W-1:0] OP_HALT   = 4'd9;

  localparam logic [FAULT_W-1:0] FAULT_NONE   = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVER   = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNDER  = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_OPCODE = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_INDEX  = 3'd4;

  // one classified instruction as it sits in the queue
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [1:0]        need;
    logic [1:0]        room;
    logic              uses_index;
    logic              unknown;
    logic              index_bad;
    logic [WORD_W-1:0] operand;
  } sbe_item_t;

endpackage

`default_nettype wire

[rtl/core/sbe_in_if.sv]
// instruction channel interface
`default_nettype none

interface sbe_in_if;
  import sbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink (input valid, input func, input operand, output ready);
endinterface

`default_nettype wire

[rtl/core/sbe_out_if.sv]
// result channel interface
`default_nettype none

interface sbe_out_if;
  import sbe_pkg::*;

  logic               valid;
  logic               ready;
  logic [IP_W-1:0]    next_ip;
  logic               print_valid;
  logic [WORD_W-1:0]  print_value;
  logic               halted;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, output next_ip, output print_valid, output print_value,
                  output halted, output fault, input ready);
  modport sink (input valid, input next_ip, input print_valid, input print_value,
                input halted, input fault, output ready);
endinterface

`default_nettype wire

[rtl/core/stack_bytecode_executor_top.sv]
// top level of the stack bytecode executor
`default_nettype none

// Stack bytecode executor. Each beat on in_ch is one instruction (opcode in func, its
// code word in operand) and yields exactly one beat on out_ch with the next fetch
// address, any printed value, the halt flag and a fault code; a faulting instruction
// leaves all state untouched, and after halt every instruction is ignored. The front
// end classifies beats into a two-entry queue, so in_ch keeps accepting while it has
// room, also while the back end works and a result waits on out_ch. The back end runs
// one instruction at a time through a sequencer around a single stack ram with one
// write and one registered read port. Const, gload, halt, faulting and ignored
// instructions go straight to the hand-over; brt, gstore and print read the top word,
// add and sub two words, ret three, and call pushes its second word in a step of its own.
// Stack contents need no clearing; reset clears globals, sp and pc and sets fp to all ones.
module stack_bytecode_executor_top #(
  parameter int STACK_DEPTH    = 64,
  parameter int GLOBAL_COUNT   = 16,
  parameter int CODE_ADDR_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sbe_in_if.sink    in_ch,
  sbe_out_if.source out_ch
);
  import sbe_pkg::*;

  // queue head between front and back
  logic      q_valid;
  logic      q_pop;
  sbe_item_t q_item;

  // front: instruction beats in, classified entries out
  sbe_front #(
    .GLOBAL_COUNT (GLOBAL_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: stack machine state, stack ram and the result register
  sbe_back #(
    .STACK_DEPTH    (STACK_DEPTH),
    .GLOBAL_COUNT   (GLOBAL_COUNT),
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/sbe_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/sbe_front.sv]
// front end: takes instruction beats, classifies them, holds them in a two-entry queue
`default_nettype none

module sbe_front #(
  parameter int GLOBAL_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sbe_in_if.sink                 in_ch,
  output      logic              q_valid,
  output      sbe_pkg::sbe_item_t q_item,
  input  wire logic              q_pop
);
  import sbe_pkg::*;

  localparam int QDEPTH = 2;

  sbe_item_t  q_r [QDEPTH];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  sbe_item_t  cls;

  // classification of the incoming beat
  always_comb begin
    cls            = '0;
    cls.func       = in_ch.func;
    cls.operand    = in_ch.operand;
    cls.index_bad  = (in_ch.operand >= 32'(GLOBAL_COUNT));
    unique case (in_ch.func) inside
      OP_ADD, OP_SUB: cls.need = 2'd2;
      OP_CONST:       cls.room = 2'd1;
      OP_BRT:         cls.need = 2'd1;
      OP_LOADG: begin
        cls.room       = 2'd1;
        cls.uses_index = 1'b1;
      end
      OP_STOREG: begin
        cls.need       = 2'd1;
        cls.uses_index = 1'b1;
      end
      OP_EMIT:        cls.need = 2'd1;
      OP_CALL:        cls.room = 2'd2;
      OP_RET:         cls.need = 2'd3;
      OP_HALT:        cls.need = 2'd0;
      default:        cls.unknown = 1'b1;
    endcase
  end

  assign in_ch.ready = (count_r != 2'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = q_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sbe_back.sv]
// back end: sequencer that executes queued instructions against the stack ram
`default_nettype none

module sbe_back #(
  parameter int STACK_DEPTH    = 64,
  parameter int GLOBAL_COUNT   = 16,
  parameter int CODE_ADDR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire sbe_pkg::sbe_item_t q_item,
  output      logic               q_pop,
  sbe_out_if.source               out_ch
);
  import sbe_pkg::*;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SP_AW = $clog2(STACK_DEPTH);
  localparam int GI_AW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
  localparam int PC_W  = CODE_ADDR_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD1   = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_RD3   = 3'd3;
  localparam logic [2:0] S_CALL2 = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  sbe_item_t          cur_r, cur_nxt;
  logic [WORD_W-1:0]  x_r, x_nxt;
  logic [FP_W-1:0]    fpt_r, fpt_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [FP_W-1:0]    fp_r, fp_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic               halt_r, halt_nxt;
  logic [WORD_W-1:0]  glb_r [GLOBAL_COUNT];
  logic [WORD_W-1:0]  glb_nxt [GLOBAL_COUNT];
  logic               res_pv_r, res_pv_nxt;
  logic [WORD_W-1:0]  res_pval_r, res_pval_nxt;
  logic [FAULT_W-1:0] res_fault_r, res_fault_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [IP_W-1:0]    out_ip_r;
  logic               out_pv_r;
  logic [WORD_W-1:0]  out_pval_r;
  logic               out_halt_r;
  logic [FAULT_W-1:0] out_fault_r;

  logic               ram_we, ram_re;
  logic [SP_AW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [SP_W-1:0]    sp_m1, sp_m2, sp_m3, sp_p1, sp_p2;
  logic [PC_W-1:0]    pc_p1, pc_p2;
  logic [FAULT_W-1:0] fault_c;

  assign sp_m1 = sp_r - SP_W'(1);
  assign sp_m2 = sp_r - SP_W'(2);
  assign sp_m3 = sp_r - SP_W'(3);
  assign sp_p1 = sp_r + SP_W'(1);
  assign sp_p2 = sp_r + SP_W'(2);
  assign pc_p1 = pc_r + PC_W'(1);
  assign pc_p2 = pc_r + PC_W'(2);

  // fault of the queue head, stack checks ahead of the index check
  always_comb begin
    fault_c = FAULT_NONE;
    if (q_item.unknown) begin
      fault_c = FAULT_OPCODE;
    end else if (sp_r < SP_W'(q_item.need)) begin
      fault_c = FAULT_UNDER;
    end else if (({1'b0, sp_r} + (SP_W+1)'(q_item.room)) > (SP_W+1)'(STACK_DEPTH)) begin
      fault_c = FAULT_OVER;
    end else if (q_item.uses_index && q_item.index_bad) begin
      fault_c = FAULT_INDEX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    fpt_nxt       = fpt_r;
    sp_nxt        = sp_r;
    fp_nxt        = fp_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    glb_nxt       = glb_r;
    res_pv_nxt    = res_pv_r;
    res_pval_nxt  = res_pval_r;
    res_fault_nxt = res_fault_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cur_nxt       = q_item;
          res_pv_nxt    = 1'b0;
          res_pval_nxt  = '0;
          res_fault_nxt = FAULT_NONE;
          state_nxt     = S_DONE;
          if (halt_r) begin
            res_fault_nxt = FAULT_NONE;
          end else if (fault_c != FAULT_NONE) begin
            res_fault_nxt = fault_c;
          end else begin
            case (q_item.func) inside
              OP_ADD, OP_SUB, OP_BRT, OP_STOREG, OP_EMIT, OP_RET: begin
                ram_re    = 1'b1;
                ram_raddr = sp_m1[SP_AW-1:0];
                state_nxt = S_RD1;
              end
              OP_CONST: begin
                ram_we    = 1'b1;
                ram_waddr = sp_r[SP_AW-1:0];
                ram_wdata = q_item.operand;
                sp_nxt    = sp_p1;
                pc_nxt    = pc_p2;
              end
              OP_LOADG: begin
                ram_we    = 1'b1;
                ram_waddr = sp_r[SP_AW-1:0];
                ram_wdata = glb_r[q_item.operand[GI_AW-1:0]];
                sp_nxt    = sp_p1;
                pc_nxt    = pc_p2;
              end
              OP_CALL: begin
                // return address first, old frame pointer next cycle
                ram_we    = 1'b1;
                ram_waddr = sp_r[SP_AW-1:0];
                ram_wdata = WORD_W'(pc_p2);
                state_nxt = S_CALL2;
              end
              OP_HALT: begin
                halt_nxt = 1'b1;
                pc_nxt   = pc_p1;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_RD1: begin
        x_nxt     = ram_rdata;
        state_nxt = S_DONE;
        case (cur_r.func) inside
          OP_BRT: begin
            pc_nxt = (ram_rdata != '0) ? PC_W'(cur_r.operand) : pc_p2;
          end
          OP_STOREG: begin
            glb_nxt[cur_r.operand[GI_AW-1:0]] = ram_rdata;
            sp_nxt = sp_m1;
            pc_nxt = pc_p2;
          end
          OP_EMIT: begin
            res_pv_nxt   = 1'b1;
            res_pval_nxt = ram_rdata;
            sp_nxt       = sp_m1;
            pc_nxt       = pc_p1;
          end
          OP_ADD, OP_SUB, OP_RET: begin
            ram_re    = 1'b1;
            ram_raddr = sp_m2[SP_AW-1:0];
            state_nxt = S_RD2;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_RD2: begin
        if (cur_r.func == OP_RET) begin
          fpt_nxt   = ram_rdata[FP_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = sp_m3[SP_AW-1:0];
          state_nxt = S_RD3;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = sp_m2[SP_AW-1:0];
          ram_wdata = (cur_r.func == OP_SUB) ? (ram_rdata - x_r) : (ram_rdata + x_r);
          sp_nxt    = sp_m1;
          pc_nxt    = pc_p1;
          state_nxt = S_DONE;
        end
      end

      S_RD3: begin
        // saved pc comes back, result replaces the three popped words
        pc_nxt    = PC_W'(ram_rdata);
        fp_nxt    = fpt_r;
        ram_we    = 1'b1;
        ram_waddr = sp_m3[SP_AW-1:0];
        ram_wdata = x_r;
        sp_nxt    = sp_m2;
        state_nxt = S_DONE;
      end

      S_CALL2: begin
        ram_we    = 1'b1;
        ram_waddr = sp_p1[SP_AW-1:0];
        ram_wdata = {{(WORD_W-FP_W){fp_r[FP_W-1]}}, fp_r};
        fp_nxt    = FP_W'(sp_p2);
        sp_nxt    = sp_p2;
        pc_nxt    = PC_W'(cur_r.operand);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      fp_r        <= '1;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < GLOBAL_COUNT; i++) begin
        glb_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      fp_r        <= fp_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
      glb_r       <= glb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    x_r         <= x_nxt;
    fpt_r       <= fpt_nxt;
    res_pv_r    <= res_pv_nxt;
    res_pval_r  <= res_pval_nxt;
    res_fault_r <= res_fault_nxt;
    if (out_load) begin
      out_ip_r    <= IP_W'(pc_r);
      out_pv_r    <= res_pv_r;
      out_pval_r  <= res_pval_r;
      out_halt_r  <= halt_r;
      out_fault_r <= res_fault_r;
    end
  end

  sbe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_ip     = out_ip_r;
  assign out_ch.print_valid = out_pv_r;
  assign out_ch.print_value = out_pval_r;
  assign out_ch.halted      = out_halt_r;
  assign out_ch.fault       = out_fault_r;

endmodule

`default_nettype wire

[rtl/core/sbe_checker.sv]
// port-level checker for the stack bytecode executor and its bind
`default_nettype none

`include "assert_macros.svh"

module sbe_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sbe_pkg::IP_W-1:0]   next_ip,
  input wire logic                       print_valid,
  input wire logic                       halted,
  input wire logic [sbe_pkg::FAULT_W-1:0] fault
);
  import sbe_pkg::*;

  logic [2:0]      pend_r;
  logic            seen_halt_r;
  logic [IP_W-1:0] last_ip_r;
  logic            in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      seen_halt_r <= 1'b0;
      last_ip_r   <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_beat) - 3'(out_beat);
      if (out_beat) begin
        seen_halt_r <= seen_halt_r || halted;
        last_ip_r   <= next_ip;
      end
    end
  end

  `SBE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SBE_ASSERT_IMP(a_no_extra, clk, rst_n, out_valid, pend_r != 3'd0, "result without instruction")
  `SBE_ASSERT_IMP(a_halt_sticky, clk, rst_n, out_valid && seen_halt_r, halted && (fault == FAULT_NONE) && !print_valid && (next_ip == last_ip_r), "activity after halt")
  `SBE_ASSERT_IMP(a_fault_keeps_ip, clk, rst_n, out_valid && (fault != FAULT_NONE), (next_ip == last_ip_r) && !print_valid, "faulting instruction moved pc")

endmodule

bind stack_bytecode_executor_top sbe_checker u_sbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .next_ip     (out_ch.next_ip),
  .print_valid (out_ch.print_valid),
  .halted      (out_ch.halted),
  .fault       (out_ch.fault)
);

`default_nettype wire
